// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: text console cell writer definitions
// Store geometry, request and response beats, control codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COL_W       = 7;
   localparam int ROW_W       = 6;

   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_SET   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_ATTR    = 2'd2;

   localparam logic [15:0] CODE_NUL    = 16'h0000;
   localparam logic [15:0] CODE_BS     = 16'h0008;
   localparam logic [15:0] CODE_LF     = 16'h000A;
   localparam logic [15:0] CODE_CR     = 16'h000D;
   localparam logic [15:0] CODE_WIDE   = 16'hFFF1;
   localparam logic [15:0] CODE_NARROW = 16'hFFF2;
   localparam logic [15:0] BLANK       = 16'h0020;

   typedef struct packed {
      logic [1:0]       func;
      logic [15:0]      code;
      logic             string_start;
      logic [ROW_W-1:0] row_sel;
      logic [COL_W-1:0] col_sel;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic [15:0]      cell_char;
      logic [6:0]       cell_attr;
      logic             cell_wide;
   } rsp_type;

   // one store word: wide flag, colour, character
   typedef struct packed {
      logic        wide;
      logic [6:0]  attr;
      logic [15:0] ch;
   } cell_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_addr = ADDR_W'(int'(r) * MAX_COLUMNS + int'(c));
   endfunction

endpackage

// ===== src/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text screen store with cursor, put-char, read-cell, set-cursor and clear.
// ----------------------------------------------------------------------------
// The request channel (req_valid/req_stall/req) carries one command beat;
// every command yields one response beat on rsp_valid/rsp_stall/rsp with the
// cursor after the command and, for read cell, the cell contents.
// One command is in flight at a time: req_stall is high from acceptance until
// the response is loaded. All cells sit in one single-port 8192 x 24 store
// with registered read data, so each step costs one store access: a wide
// glyph writes its cell, then reads and rewrites the cell to its right; a
// pad is written first when a glyph does not fit, and a glyph that wraps
// adds a line feed; a line feed on the last row scrolls by copying each row
// up one and blanking the last row; clear writes every cell of the store.
// The response sits in an output register, so a new command can be taken
// while an earlier response waits under rsp_stall; a response is loaded only
// once that register is free.
// Reset puts the cursor at 0,0 and the registers at 80 columns, 25 rows,
// colour 7; the store is undefined until the first clear. Registers are to be
// written on the csr port only while the block is idle, a rule not enforced.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcw_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcw_pkg::rsp_type  rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import tcw_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_DEC    = 15'b000000000000010,
      S_BS_CHK = 15'b000000000000100,
      S_G1     = 15'b000000000001000,
      S_G2     = 15'b000000000010000,
      S_G3     = 15'b000000000100000,
      S_G4     = 15'b000000001000000,
      S_G5     = 15'b000000010000000,
      S_LF     = 15'b000000100000000,
      S_SC_RD  = 15'b000001000000000,
      S_SC_WR  = 15'b000010000000000,
      S_BLANK  = 15'b000100000000000,
      S_CLR    = 15'b001000000000000,
      S_RD     = 15'b010000000000000,
      S_DONE   = 15'b100000000000000
   } state_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   req_type          req_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             gw_ff, gw_in;
   logic [ROW_W-1:0] sr_ff, sr_in;
   logic [COL_W-1:0] sc_ff, sc_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   cell_type         ocell_ff, ocell_in;
   logic [7:0]       cols_cfg_ff;
   logic [6:0]       rows_cfg_ff;
   logic [6:0]       attr_ff;

   cell_type         mem [DEPTH];
   cell_type         rdata_ff, wdata;
   logic [ADDR_W-1:0] addr;
   logic             we, re;

   logic [COL_W:0]   cols;
   logic [ROW_W:0]   rows;
   logic [1:0]       w;
   logic [COL_W:0]   col_x, col_w, col_p1;
   logic [COL_W-1:0] bs_col;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      cols = (cols_cfg_ff == 8'd0) ? (COL_W+1)'(1)
           : (cols_cfg_ff > 8'(MAX_COLUMNS)) ? (COL_W+1)'(MAX_COLUMNS) : cols_cfg_ff;
      rows = (rows_cfg_ff == 7'd0) ? (ROW_W+1)'(1)
           : (rows_cfg_ff > 7'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : rows_cfg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= 8'd80;
         rows_cfg_ff <= 7'd25;
         attr_ff     <= 7'd7;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLUMNS: cols_cfg_ff <= csr_data;
            CSR_ROWS:    rows_cfg_ff <= csr_data[6:0];
            CSR_ATTR:    attr_ff     <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      if (re) rdata_ff <= mem[addr];
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      gw_in        = gw_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      cnt_in       = cnt_ff;
      ocell_in     = ocell_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      we           = 1'b0;
      re           = 1'b0;
      addr         = cell_addr(row_ff, col_ff);
      wdata        = '{wide: 1'b0, attr: attr_ff, ch: BLANK};
      w            = gw_ff ? 2'd2 : 2'd1;
      col_x        = {1'b0, col_ff};
      col_w        = col_x + (COL_W+1)'(w);
      col_p1       = col_x + (COL_W+1)'(1);
      bs_col       = (col_ff == '0) ? COL_W'(cols - 1'b1) : col_ff - 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DEC;
         end
         S_DEC: begin
            ocell_in = '0;
            state_in = S_DONE;
            case (req_ff.func)
               FUNC_PUT: begin
                  if (req_ff.string_start) gw_in = 1'b0;
                  case (req_ff.code)
                     CODE_NUL: ;
                     CODE_BS: begin
                        if (!(col_ff == '0 && row_ff == '0)) begin
                           if (col_ff == '0) row_in = row_ff - 1'b1;
                           col_in = bs_col;
                           if (bs_col != '0) begin
                              re       = 1'b1;
                              addr     = cell_addr(row_in, bs_col - 1'b1);
                              state_in = S_BS_CHK;
                           end
                        end
                     end
                     CODE_LF: begin
                        ret_in   = S_DONE;
                        state_in = S_LF;
                     end
                     CODE_CR: col_in = '0;
                     default: begin
                        if (col_x >= cols) begin
                           col_in   = '0;
                           ret_in   = S_G1;
                           state_in = S_LF;
                        end else begin
                           state_in = S_G1;
                        end
                     end
                  endcase
               end
               FUNC_READ: begin
                  if ({1'b0, req_ff.row_sel} < rows && {1'b0, req_ff.col_sel} < cols) begin
                     re       = 1'b1;
                     addr     = cell_addr(req_ff.row_sel, req_ff.col_sel);
                     state_in = S_RD;
                  end
               end
               FUNC_SET: begin
                  if ({1'b0, req_ff.row_sel} < rows && {1'b0, req_ff.col_sel} < cols) begin
                     row_in = req_ff.row_sel;
                     col_in = req_ff.col_sel;
                  end
               end
               default: begin
                  cnt_in   = '0;
                  state_in = S_CLR;
               end
            endcase
         end
         S_BS_CHK: begin
            if (rdata_ff.wide) col_in = col_ff - 1'b1;
            state_in = S_DONE;
         end
         S_RD: begin
            ocell_in = rdata_ff;
            state_in = S_DONE;
         end
         S_G1: begin
            if (req_ff.code == CODE_WIDE || req_ff.code == CODE_NARROW) begin
               gw_in    = (req_ff.code == CODE_WIDE);
               state_in = S_DONE;
            end else if (col_w > cols) begin
               // glyph does not fit: pad with a wide space
               we    = 1'b1;
               wdata = '{wide: 1'b1, attr: attr_ff, ch: BLANK};
               if (col_p1 >= cols) begin
                  col_in   = '0;
                  ret_in   = S_G2;
                  state_in = S_LF;
               end else begin
                  col_in   = col_p1[COL_W-1:0];
                  state_in = S_G2;
               end
            end else begin
               state_in = S_G3;
            end
         end
         S_G2: begin
            state_in = (col_w > cols) ? S_DONE : S_G3;
         end
         S_G3: begin
            we = 1'b1;
            if (gw_ff) begin
               wdata    = '{wide: 1'b1, attr: attr_ff, ch: req_ff.code};
               state_in = S_G4;
            end else begin
               wdata = '{wide: 1'b0, attr: attr_ff, ch: req_ff.code};
               if (col_p1 >= cols) begin
                  col_in   = '0;
                  ret_in   = S_DONE;
                  state_in = S_LF;
               end else begin
                  col_in   = col_p1[COL_W-1:0];
                  state_in = S_DONE;
               end
            end
         end
         S_G4: begin
            re       = 1'b1;
            addr     = cell_addr(row_ff, col_p1[COL_W-1:0]);
            state_in = S_G5;
         end
         S_G5: begin
            // right half of a wide glyph loses its wide flag
            we    = 1'b1;
            addr  = cell_addr(row_ff, col_p1[COL_W-1:0]);
            wdata = '{wide: 1'b0, attr: rdata_ff.attr, ch: rdata_ff.ch};
            if (col_w >= cols) begin
               col_in   = '0;
               ret_in   = S_DONE;
               state_in = S_LF;
            end else begin
               col_in   = col_w[COL_W-1:0];
               state_in = S_DONE;
            end
         end
         S_LF: begin
            if ({1'b0, row_ff} + (ROW_W+1)'(1) < rows) begin
               row_in   = row_ff + 1'b1;
               state_in = ret_ff;
            end else begin
               row_in   = ROW_W'(rows - 1'b1);
               sr_in    = '0;
               sc_in    = '0;
               state_in = (rows > (ROW_W+1)'(1)) ? S_SC_RD : S_BLANK;
            end
         end
         S_SC_RD: begin
            re       = 1'b1;
            addr     = cell_addr(sr_ff + 1'b1, sc_ff);
            state_in = S_SC_WR;
         end
         S_SC_WR: begin
            we    = 1'b1;
            addr  = cell_addr(sr_ff, sc_ff);
            wdata = rdata_ff;
            state_in = S_SC_RD;
            if ({1'b0, sc_ff} + (COL_W+1)'(1) == cols) begin
               sc_in = '0;
               if ({1'b0, sr_ff} + (ROW_W+1)'(2) == rows) state_in = S_BLANK;
               else sr_in = sr_ff + 1'b1;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         S_BLANK: begin
            we   = 1'b1;
            addr = cell_addr(ROW_W'(rows - 1'b1), sc_ff);
            if ({1'b0, sc_ff} + (COL_W+1)'(1) == cols) state_in = ret_ff;
            else sc_in = sc_ff + 1'b1;
         end
         S_CLR: begin
            we   = 1'b1;
            addr = cnt_ff;
            if (cnt_ff == ADDR_W'(DEPTH - 1)) begin
               row_in   = '0;
               col_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_DONE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         gw_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         gw_ff        <= gw_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff    <= sr_in;
      sc_ff    <= sc_in;
      cnt_ff   <= cnt_in;
      ocell_ff <= ocell_in;
      if (state_ff == S_IDLE && req_valid) req_ff <= req;
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.cursor_row <= row_ff;
         rsp_ff.cursor_col <= col_ff;
         rsp_ff.cell_char  <= ocell_ff.ch;
         rsp_ff.cell_attr  <= ocell_ff.attr;
         rsp_ff.cell_wide  <= ocell_ff.wide;
      end
   end

   // accepted beat always goes to decode
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DEC)
      else $error("accepted request not decoded");

   // leaving done always presents a response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall) |=> rsp_valid_ff)
      else $error("response lost");

   // store is never written while waiting for a command
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !we)
      else $error("store write outside a command");

   // scroll copy stays above the last row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SC_WR |-> {1'b0, sr_ff} + (ROW_W+1)'(1) < rows)
      else $error("scroll row out of range");

endmodule
